// ===== hdl/hough_line_angle_clustering_macros.svh =====
// Assertion macros shared by the angle clustering RTL.
`ifndef HOUGH_LINE_ANGLE_CLUSTERING_MACROS_SVH
`define HOUGH_LINE_ANGLE_CLUSTERING_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst is high.
`define HLAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hlac: check failed in %m");
// Next-cycle implication, sampled on clk, off while rst is high.
`define HLAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hlac: check failed in %m");
`else
`define HLAC_ASSERT_IMP(lbl, ante, cons)
`define HLAC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/hlac_pkg.sv =====
// Types and constants of the Hough line angle clustering block.
`timescale 1ns / 1ps
`default_nettype none
package hlac_pkg;

  localparam int ANGLE_FRAC_BITS = 13;

  localparam int RHO_W     = 17;
  localparam int THETA_W   = 15;
  localparam int STATUS_W  = 3;
  localparam int IDX_W     = 4;
  localparam int COUNT_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam int RSUM_W  = 25;
  localparam int TSUM_W  = 23;
  localparam int DIV_W   = 25;
  localparam int ENTRY_W = RSUM_W + TSUM_W + COUNT_W;

  // 0.8 and 0.05 rad in Q(ANGLE_FRAC_BITS), rounded
  localparam logic [THETA_W-1:0] MIN_THETA_RST =
    THETA_W'(((4 << ANGLE_FRAC_BITS) + 2) / 5);
  localparam logic [THETA_W-1:0] TOL_RST =
    THETA_W'(((1 << ANGLE_FRAC_BITS) + 10) / 20);

  typedef enum logic [0:0] {
    FUNC_ADD   = 1'b0,
    FUNC_FLUSH = 1'b1
  } func_t;

  typedef enum logic [0:0] {
    KIND_ADD   = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_JOINED = 3'd0,
    ST_NEW    = 3'd1,
    ST_REJECT = 3'd2,
    ST_FULL   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_THETA = 1'b0,
    CFG_TOL       = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK,
    S_RD,
    S_LAT,
    S_MUL,
    S_TST,
    S_NEW,
    S_DIV,
    S_DIV_WAIT,
    S_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    load_in;
    logic    slot_clr;
    logic    slot_inc;
    logic    rd_en;
    logic    lat;
    logic    mul;
    logic    join_wr;
    logic    new_wr;
    logic    used_clr;
    logic    div_start;
    logic    out_load;
    logic    out_zero;
    logic    out_last;
    kind_t   out_kind;
    status_t out_status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_flush;
    logic below_min;
    logic used_zero;
    logic used_full;
    logic slot_last;
    logic match;
    logic cnt_sat;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/hlac_if.sv =====
// Channel interfaces: line input, result output and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface hlac_in_if;
  import hlac_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic signed [RHO_W-1:0]   rho;
  logic        [THETA_W-1:0] theta;
  modport source (output valid, func, rho, theta, input ready);
  modport sink   (input valid, func, rho, theta, output ready);
endinterface

interface hlac_out_if;
  import hlac_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic        [STATUS_W-1:0] status;
  logic        [IDX_W-1:0]    cluster_index;
  logic signed [RHO_W-1:0]    mean_rho;
  logic        [THETA_W-1:0]  mean_theta;
  logic        [COUNT_W-1:0]  member_count;
  logic                       last;
  modport source (output valid, kind, status, cluster_index, mean_rho, mean_theta,
                  member_count, last, input ready);
  modport sink   (input valid, kind, status, cluster_index, mean_rho, mean_theta,
                  member_count, last, output ready);
endinterface

interface hlac_cfg_if;
  import hlac_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [THETA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/hlac_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module hlac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/hlac_div.sv =====
// Bit-serial restoring divider: two dividends over one 8-bit divisor.
`timescale 1ns / 1ps
`default_nettype none
`include "hough_line_angle_clustering_macros.svh"
module hlac_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [hlac_pkg::DIV_W-1:0]    dividend_a,
  input  logic [hlac_pkg::DIV_W-1:0]    dividend_b,
  input  logic [hlac_pkg::COUNT_W-1:0]  divisor,
  output logic [hlac_pkg::DIV_W-1:0]    quot_a,
  output logic [hlac_pkg::DIV_W-1:0]    quot_b,
  output logic                          done
);
  import hlac_pkg::*;

  localparam int CW = $clog2(DIV_W);

  logic               busy;
  logic [CW-1:0]      cnt;
  logic [DIV_W-1:0]   qa, qb;
  logic [COUNT_W-1:0] ra, rb, dv;
  logic [COUNT_W:0]   trial_a, trial_b, sub_a, sub_b;
  logic               ge_a, ge_b;

  assign trial_a = {ra, qa[DIV_W-1]};
  assign trial_b = {rb, qb[DIV_W-1]};
  assign sub_a   = trial_a - {1'b0, dv};
  assign sub_b   = trial_b - {1'b0, dv};
  assign ge_a    = trial_a >= {1'b0, dv};
  assign ge_b    = trial_b >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - CW'(1);
        end
      end
    end
  end

  // dividend bits shift out at the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      qa <= dividend_a;
      qb <= dividend_b;
      ra <= '0;
      rb <= '0;
      dv <= divisor;
    end else if (busy) begin
      qa <= {qa[DIV_W-2:0], ge_a};
      qb <= {qb[DIV_W-2:0], ge_b};
      ra <= ge_a ? sub_a[COUNT_W-1:0] : trial_a[COUNT_W-1:0];
      rb <= ge_b ? sub_b[COUNT_W-1:0] : trial_b[COUNT_W-1:0];
    end
  end

  assign quot_a = qa;
  assign quot_b = qb;

  `HLAC_ASSERT_IMP(a_start_idle, start, !busy)
  `HLAC_ASSERT_IMP(a_divisor_nonzero, start, divisor != '0)
  `HLAC_ASSERT_NXT(a_done_after_last, busy && (cnt == '0) && !start, done && !busy)
endmodule
`default_nettype wire

// ===== hdl/hlac_datapath.sv =====
// Datapath: registers, cluster table, match test, divider and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "hough_line_angle_clustering_macros.svh"
module hlac_datapath #(
  parameter int MAX_CLUSTERS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_func,
  input  logic signed [hlac_pkg::RHO_W-1:0]    in_rho,
  input  logic        [hlac_pkg::THETA_W-1:0]  in_theta,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [hlac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [hlac_pkg::THETA_W-1:0]  cfg_data,
  input  hlac_pkg::cmd_t                       cmd,
  output hlac_pkg::sts_t                       sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_kind,
  output logic        [hlac_pkg::STATUS_W-1:0] out_status,
  output logic        [hlac_pkg::IDX_W-1:0]    out_cluster_index,
  output logic signed [hlac_pkg::RHO_W-1:0]    out_mean_rho,
  output logic        [hlac_pkg::THETA_W-1:0]  out_mean_theta,
  output logic        [hlac_pkg::COUNT_W-1:0]  out_member_count,
  output logic                                 out_last
);
  import hlac_pkg::*;

  localparam int SW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int UW = $clog2(MAX_CLUSTERS + 1);

  // captured item and configuration
  logic                func_r;
  logic [RHO_W-1:0]    rho_r;
  logic [THETA_W-1:0]  theta_r;
  logic [THETA_W-1:0]  min_theta;
  logic [THETA_W-1:0]  tol;

  logic [UW-1:0]       used;
  logic [SW-1:0]       slot;

  // working copy of one table entry
  logic [RSUM_W-1:0]   e_rsum;
  logic [TSUM_W-1:0]   e_tsum;
  logic [COUNT_W-1:0]  e_cnt;
  logic [TSUM_W-1:0]   p_theta, p_tol;

  logic [RSUM_W-1:0]   rho_ext;
  logic [ENTRY_W-1:0]  new_entry, join_entry, ram_wdata, ram_rdata;
  logic [SW-1:0]       ram_waddr;
  logic                ram_we;
  logic [TSUM_W:0]     diff, absd;
  logic                rneg;
  logic [DIV_W-1:0]    rmag, qa, qb, qa_sgn;
  logic                div_done;

  assign cfg_ready = 1'b1;

  assign rho_ext    = {{(RSUM_W - RHO_W){rho_r[RHO_W-1]}}, rho_r};
  assign new_entry  = {rho_ext, TSUM_W'(theta_r), COUNT_W'(1)};
  assign join_entry = {e_rsum + rho_ext, e_tsum + TSUM_W'(theta_r), e_cnt + COUNT_W'(1)};
  assign ram_we     = cmd.join_wr | cmd.new_wr;
  assign ram_waddr  = cmd.new_wr ? used[SW-1:0] : slot;
  assign ram_wdata  = cmd.new_wr ? new_entry : join_entry;

  hlac_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CLUSTERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (slot),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_theta <= MIN_THETA_RST;
      tol       <= TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIN_THETA: min_theta <= cfg_data;
        CFG_TOL:       tol       <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      slot <= '0;
    end else begin
      if (cmd.used_clr) begin
        used <= '0;
      end else if (cmd.new_wr) begin
        used <= used + UW'(1);
      end
      priority if (cmd.slot_clr) begin
        slot <= '0;
      end else if (cmd.new_wr) begin
        slot <= used[SW-1:0];
      end else if (cmd.slot_inc) begin
        slot <= slot + SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      func_r  <= in_func;
      rho_r   <= in_rho;
      theta_r <= in_theta;
    end
    priority if (cmd.lat) begin
      {e_rsum, e_tsum, e_cnt} <= ram_rdata;
    end else if (cmd.new_wr) begin
      {e_rsum, e_tsum, e_cnt} <= new_entry;
    end else if (cmd.join_wr) begin
      {e_rsum, e_tsum, e_cnt} <= join_entry;
    end
    if (cmd.mul) begin
      p_theta <= TSUM_W'(theta_r) * TSUM_W'(e_cnt);
      p_tol   <= TSUM_W'(tol) * TSUM_W'(e_cnt);
    end
  end

  // |theta*n - theta_sum| < tol*n
  assign diff = {1'b0, p_theta} - {1'b0, e_tsum};
  assign absd = diff[TSUM_W] ? (~diff + (TSUM_W + 1)'(1)) : diff;

  assign sts.is_flush  = (func_r == FUNC_FLUSH);
  assign sts.below_min = theta_r < min_theta;
  assign sts.used_zero = (used == '0);
  assign sts.used_full = (used == UW'(MAX_CLUSTERS));
  assign sts.slot_last = ((UW'(slot) + UW'(1)) == used);
  assign sts.match     = absd < {1'b0, p_tol};
  assign sts.cnt_sat   = &e_cnt;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid || out_ready;

  // divide magnitudes, restore the sign of rho afterwards
  assign rneg   = e_rsum[RSUM_W-1];
  assign rmag   = rneg ? (~e_rsum + RSUM_W'(1)) : e_rsum;
  assign qa_sgn = rneg ? (~qa + DIV_W'(1)) : qa;

  hlac_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .dividend_a (rmag),
    .dividend_b (DIV_W'(e_tsum)),
    .divisor    (e_cnt),
    .quot_a     (qa),
    .quot_b     (qb),
    .done       (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind   <= cmd.out_kind;
      out_status <= cmd.out_status;
      out_last   <= cmd.out_last;
      if (cmd.out_zero) begin
        out_cluster_index <= '0;
        out_mean_rho      <= '0;
        out_mean_theta    <= '0;
        out_member_count  <= '0;
      end else begin
        out_cluster_index <= IDX_W'(slot);
        out_mean_rho      <= qa_sgn[RHO_W-1:0];
        out_mean_theta    <= qb[THETA_W-1:0];
        out_member_count  <= e_cnt;
      end
    end
  end

  `HLAC_ASSERT_IMP(a_load_when_free, cmd.out_load, !out_valid || out_ready)
  `HLAC_ASSERT_IMP(a_no_new_when_full, cmd.new_wr, used != UW'(MAX_CLUSTERS))
  `HLAC_ASSERT_NXT(a_clear_empties, cmd.used_clr, used == '0)
endmodule
`default_nettype wire

// ===== hdl/hlac_ctrl.sv =====
// Controller: sequences search, update, division and result transfers.
`timescale 1ns / 1ps
`default_nettype none
module hlac_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  hlac_pkg::sts_t sts,
  output hlac_pkg::cmd_t cmd
);
  import hlac_pkg::*;

  state_t  state, state_next;
  status_t res_status, res_status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_JOINED;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.out_kind    = sts.is_flush ? KIND_FLUSH : KIND_ADD;
    cmd.out_status  = res_status;
    cmd.out_zero    = (res_status == ST_REJECT) || (res_status == ST_FULL) ||
                      (res_status == ST_EMPTY);
    cmd.out_last    = !sts.is_flush || sts.used_zero || sts.slot_last;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHK;
        end
      end
      S_CHK: begin
        cmd.slot_clr = 1'b1;
        if (sts.is_flush) begin
          if (sts.used_zero) begin
            res_status_next = ST_EMPTY;
            state_next      = S_EMIT;
          end else begin
            res_status_next = ST_JOINED;
            state_next      = S_RD;
          end
        end else if (sts.below_min) begin
          res_status_next = ST_REJECT;
          state_next      = S_EMIT;
        end else if (sts.used_zero) begin
          state_next = S_NEW;
        end else begin
          state_next = S_RD;
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_LAT;
      end
      S_LAT: begin
        cmd.lat    = 1'b1;
        state_next = sts.is_flush ? S_DIV : S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_TST;
      end
      S_TST: begin
        if (sts.match) begin
          // a saturated cluster still reports joined but keeps its sums
          res_status_next = ST_JOINED;
          cmd.join_wr     = !sts.cnt_sat;
          state_next      = S_DIV;
        end else if (sts.slot_last) begin
          state_next = S_NEW;
        end else begin
          cmd.slot_inc = 1'b1;
          state_next   = S_RD;
        end
      end
      S_NEW: begin
        if (sts.used_full) begin
          res_status_next = ST_FULL;
          state_next      = S_EMIT;
        end else begin
          cmd.new_wr      = 1'b1;
          res_status_next = ST_NEW;
          state_next      = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.is_flush && !sts.used_zero && !sts.slot_last) begin
            cmd.slot_inc = 1'b1;
            state_next   = S_RD;
          end else begin
            cmd.used_clr = sts.is_flush;
            state_next   = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/hough_line_angle_clustering.sv =====
// Top level: angle clustering of Hough lines, controller plus datapath.
//
//  channel   dir  handshake       payload
//  lines     in   valid / ready   func, rho, theta
//  results   out  valid / ready   kind, status, cluster_index, mean_rho,
//                                 mean_theta, member_count, last
//  cfg       in   valid / ready   index, data (ready always high)
//
// One item at a time. Rejected adds and empty flushes skip the table; a full-table
// add searches every slot first. Joins, new clusters and each cluster reported by a
// flush run the 25-step serial divider, and each searched slot takes one table read.
// Reset is synchronous and empties the table. A stalled result holds in the output
// register; the next result stalls the input.
`timescale 1ns / 1ps
`default_nettype none
module hough_line_angle_clustering #(
  parameter int MAX_CLUSTERS = 16
) (
  input  logic              clk,
  input  logic              rst,
  hlac_in_if.sink           lines,
  hlac_out_if.source        results,
  hlac_cfg_if.sink          cfg
);
  import hlac_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hlac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (lines.valid),
    .in_ready (lines.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hlac_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .in_func           (lines.func),
    .in_rho            (lines.rho),
    .in_theta          (lines.theta),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .cmd               (cmd),
    .sts               (sts),
    .out_ready         (results.ready),
    .out_valid         (results.valid),
    .out_kind          (results.kind),
    .out_status        (results.status),
    .out_cluster_index (results.cluster_index),
    .out_mean_rho      (results.mean_rho),
    .out_mean_theta    (results.mean_theta),
    .out_member_count  (results.member_count),
    .out_last          (results.last)
  );
endmodule
`default_nettype wire
